// ----- hw/rtl/hrcf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hrcf_pkg
// shared constants, types and helpers of the hsv/rgb cell formatter
// ----------------------------------------------------------------------------
package hrcf_pkg;

	// grid defaults
	localparam int HRCF_COLUMNS = 128;
	localparam int HRCF_ROWS    = 64;

	// stream widths
	localparam int S_TDATA_W = 96;
	localparam int M_TDATA_W = 120;

	// palette size after reset
	localparam logic [8:0] PALETTE_RESET = 9'd10;

	// request kinds carried in tuser
	localparam logic REQ_RGB = 1'b0;
	localparam logic REQ_HSV = 1'b1;

	// hue arithmetic, 1/16 degree units
	localparam logic [17:0] HUE_BIAS      = 18'd34560;   // six full turns
	localparam logic [9:0]  HUE_SECTOR    = 10'd960;     // 60 degrees
	localparam logic [17:0] SECTOR_FP     = 18'd245760;  // 960 * 256
	localparam logic [12:0] DIV15_MUL     = 13'd4370;    // 2^16 / 15, rounded up
	localparam logic [5:0]  DIV6_MUL      = 6'd43;       // 2^8 / 6, rounded up
	localparam logic [6:0]  SECTOR_COUNT  = 7'd6;
	localparam logic [8:0]  UNIT_FP       = 9'd256;

	// colour wheel sectors
	localparam logic [2:0] SECT_RED     = 3'd0;
	localparam logic [2:0] SECT_YELLOW  = 3'd1;
	localparam logic [2:0] SECT_GREEN   = 3'd2;
	localparam logic [2:0] SECT_CYAN    = 3'd3;
	localparam logic [2:0] SECT_BLUE    = 3'd4;

	// ascii digit base
	localparam logic [7:0] ASCII_ZERO = 8'h30;

	// per-stage load enables of the colour pipe
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} hrcf_adv_t;

	// saturate a 1/256 fixed-point level at 1.0
	function automatic logic [8:0] sat_unit(input logic [8:0] v);
		return (v > UNIT_FP) ? UNIT_FP : v;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/hrcf_hsv_pipe.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hrcf_hsv_pipe
// five-stage colour path: hue wrap, sector split, p/q/t products, rgb select
// ----------------------------------------------------------------------------
module hrcf_hsv_pipe
	import hrcf_pkg::*;
(
	input  wire logic        clk,
	input  wire hrcf_adv_t   adv,
	input  wire logic        req_type,
	input  wire logic [15:0] hue,
	input  wire logic [8:0]  saturation,
	input  wire logic [8:0]  brightness,
	input  wire logic [7:0]  red_in,
	input  wire logic [7:0]  green_in,
	input  wire logic [7:0]  blue_in,
	output logic      [7:0]  red,
	output logic      [7:0]  green,
	output logic      [7:0]  blue
);

	// stage 1: bias hue positive, coarse quotient by 960
	logic [17:0] hue_sum;
	logic [10:0] hue_blk;
	logic [23:0] blk_prod;

	logic        type_s1;
	logic [16:0] hue_s1;
	logic [6:0]  quo_s1;
	logic [8:0]  sat_s1, val_s1;
	logic [7:0]  r_s1, g_s1, b_s1;

	assign hue_sum  = {{2{hue[15]}}, hue} + HUE_BIAS;
	assign hue_blk  = hue_sum[16:6];
	assign blk_prod = 24'(hue_blk) * 24'(DIV15_MUL);

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			type_s1 <= req_type;
			hue_s1  <= hue_sum[16:0];
			quo_s1  <= blk_prod[22:16];
			sat_s1  <= sat_unit(saturation);
			val_s1  <= sat_unit(brightness);
			r_s1    <= red_in;
			g_s1    <= green_in;
			b_s1    <= blue_in;
		end
	end

	// stage 2: fraction within sector, sector number, 255*v
	logic [16:0] sect_base, frac_wide;
	logic [12:0] six_prod;
	logic [6:0]  sect_wide;

	logic        type_s2;
	logic [9:0]  frac_s2;
	logic [2:0]  sect_s2;
	logic [8:0]  sat_s2;
	logic [16:0] v255_s2;
	logic [7:0]  r_s2, g_s2, b_s2;

	assign sect_base = 17'(quo_s1) * 17'(HUE_SECTOR);
	assign frac_wide = hue_s1 - sect_base;
	assign six_prod  = 13'(quo_s1) * 13'(DIV6_MUL);
	assign sect_wide = quo_s1 - 7'(six_prod[12:8]) * SECTOR_COUNT;

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			type_s2 <= type_s1;
			frac_s2 <= frac_wide[9:0];
			sect_s2 <= sect_wide[2:0];
			sat_s2  <= sat_s1;
			v255_s2 <= {val_s1, 8'b0} - 17'(val_s1);
			r_s2    <= r_s1;
			g_s2    <= g_s1;
			b_s2    <= b_s1;
		end
	end

	// stage 3: s*f, s*(960-f), p and v channels
	logic [9:0]  frac_rem;
	logic [8:0]  sat_inv;
	logic [25:0] p_prod;

	logic        type_s3;
	logic [2:0]  sect_s3;
	logic [17:0] sf_s3, st_s3;
	logic [16:0] v255_s3;
	logic [7:0]  pc_s3, vc_s3;
	logic [7:0]  r_s3, g_s3, b_s3;

	assign frac_rem = HUE_SECTOR - frac_s2;
	assign sat_inv  = UNIT_FP - sat_s2;
	assign p_prod   = 26'(v255_s2) * 26'(sat_inv);

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			type_s3 <= type_s2;
			sect_s3 <= sect_s2;
			sf_s3   <= 18'(sat_s2) * 18'(frac_s2);
			st_s3   <= 18'(sat_s2) * 18'(frac_rem);
			v255_s3 <= v255_s2;
			pc_s3   <= p_prod[23:16];
			vc_s3   <= v255_s2[15:8];
			r_s3    <= r_s2;
			g_s3    <= g_s2;
			b_s3    <= b_s2;
		end
	end

	// stage 4: 255*v*(245760 - s*f) and 255*v*(245760 - s*(960-f)) over 2^22, for q and t
	logic [17:0] q_fac, t_fac;
	logic [34:0] q_prod, t_prod;

	logic        type_s4;
	logic [2:0]  sect_s4;
	logic [11:0] zq_s4, zt_s4;
	logic [7:0]  pc_s4, vc_s4;
	logic [7:0]  r_s4, g_s4, b_s4;

	assign q_fac  = SECTOR_FP - sf_s3;
	assign t_fac  = SECTOR_FP - st_s3;
	assign q_prod = 35'(v255_s3) * 35'(q_fac);
	assign t_prod = 35'(v255_s3) * 35'(t_fac);

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			type_s4 <= type_s3;
			sect_s4 <= sect_s3;
			zq_s4   <= q_prod[33:22];
			zt_s4   <= t_prod[33:22];
			pc_s4   <= pc_s3;
			vc_s4   <= vc_s3;
			r_s4    <= r_s3;
			g_s4    <= g_s3;
			b_s4    <= b_s3;
		end
	end

	// stage 5: remaining divide by 15, sector select, rgb bypass
	logic [24:0] qd_prod, td_prod;
	logic [7:0]  qc, tc;
	logic [7:0]  red_nx, green_nx, blue_nx;

	assign qd_prod = 25'(zq_s4) * 25'(DIV15_MUL);
	assign td_prod = 25'(zt_s4) * 25'(DIV15_MUL);
	assign qc      = qd_prod[23:16];
	assign tc      = td_prod[23:16];

	always_comb begin
		if (type_s4 == REQ_RGB) begin
			red_nx   = r_s4;
			green_nx = g_s4;
			blue_nx  = b_s4;
		end else begin
			case (sect_s4)
				SECT_RED: begin
					red_nx = vc_s4; green_nx = tc;    blue_nx = pc_s4;
				end
				SECT_YELLOW: begin
					red_nx = qc;    green_nx = vc_s4; blue_nx = pc_s4;
				end
				SECT_GREEN: begin
					red_nx = pc_s4; green_nx = vc_s4; blue_nx = tc;
				end
				SECT_CYAN: begin
					red_nx = pc_s4; green_nx = qc;    blue_nx = vc_s4;
				end
				SECT_BLUE: begin
					red_nx = tc;    green_nx = pc_s4; blue_nx = vc_s4;
				end
				default: begin
					red_nx = vc_s4; green_nx = pc_s4; blue_nx = qc;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s5) begin
			red   <= red_nx;
			green <= green_nx;
			blue  <= blue_nx;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/hsv_rgb_cell_formatter_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_rgb_cell_formatter_core
// formats one coloured character write: cell number, rgb bytes, their ascii
// digits and the palette slot of the shade
// ----------------------------------------------------------------------------
//
// channel   direction  handshake          carries
// s_*       in         tvalid / tready    one cell write request
// m_*       out        tvalid / tready    one formatted result
// cfg_*     in         valid / ready      palette size (9 bits)
//
// every request gives exactly one result
// one request a cycle is taken unless m_tready stalls a full six-register pipeline
// valid bits travel with the data; a stalled result holds the full stages behind it
// a stage takes new data whenever it is empty or the stage after it moves
// arst_n clears the valid bits and sets the palette size to ten
// cfg_ready is always high; the palette size is read by stage two
//
module hsv_rgb_cell_formatter_core
	import hrcf_pkg::*;
#(
	parameter int COLUMNS = HRCF_COLUMNS,
	parameter int ROWS    = HRCF_ROWS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// request stream
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// row[11:0] column[23:12] shade[32:24] hue[48:33] saturation[57:49]
	// brightness[66:58] red_in[74:67] green_in[82:75] blue_in[90:83]
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	// req_type[0]
	input  wire logic [0:0]           s_tuser,
	// result stream
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// cell_index[12:0] red[20:13] green[28:21] blue[36:29] red_text[60:37]
	// green_text[84:61] blue_text[108:85] palette_slot[116:109]
	output logic      [M_TDATA_W-1:0] m_tdata,
	// palette size write
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [8:0]           cfg_data
);

	localparam int RowW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int ColW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

	// ascii digits of a byte, hundreds in the top byte
	function automatic logic [23:0] byte_text(input logic [7:0] b);
		logic [1:0]  hund;
		logic [7:0]  rest;
		logic [14:0] tprod;
		logic [3:0]  tens;
		logic [7:0]  ones;
		hund  = (b >= 8'd200) ? 2'd2 : ((b >= 8'd100) ? 2'd1 : 2'd0);
		rest  = b - 8'(hund) * 8'd100;
		tprod = 15'(rest) * 15'd205;
		tens  = tprod[14:11];
		ones  = rest - 8'(tens) * 8'd10;
		return {ASCII_ZERO + 8'(hund), ASCII_ZERO + 8'(tens), ASCII_ZERO + ones};
	endfunction

	// request fields
	logic [11:0] in_row, in_col;
	logic [8:0]  in_shade;

	assign in_row   = s_tdata[11:0];
	assign in_col   = s_tdata[23:12];
	assign in_shade = s_tdata[32:24];

	// pipeline control: a stage loads when empty or when the next one moves
	logic [6:1] vld_q;
	logic [6:1] rdy;
	hrcf_adv_t  adv;

	always_comb begin
		rdy[6] = !vld_q[6] || m_tready;
		for (int k = 5; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign adv      = '{s1: rdy[1], s2: rdy[2], s3: rdy[3], s4: rdy[4], s5: rdy[5]};
	assign s_tready = rdy[1];
	assign m_tvalid = vld_q[6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1]) begin
				vld_q[1] <= s_tvalid;
			end
			for (int k = 2; k <= 6; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// palette size register
	logic [8:0] palette_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_q <= PALETTE_RESET;
		end else if (cfg_valid) begin
			palette_q <= cfg_data;
		end
	end

	// colour path, stages one to five
	logic [7:0] red_s5, green_s5, blue_s5;

	hrcf_hsv_pipe u_hsv (
		.clk        (clk),
		.adv        (adv),
		.req_type   (s_tuser[0]),
		.hue        (s_tdata[48:33]),
		.saturation (s_tdata[57:49]),
		.brightness (s_tdata[66:58]),
		.red_in     (s_tdata[74:67]),
		.green_in   (s_tdata[82:75]),
		.blue_in    (s_tdata[90:83]),
		.red        (red_s5),
		.green      (green_s5),
		.blue       (blue_s5)
	);

	// stage 1: clamp row and column to the grid, saturate shade
	logic [RowW-1:0] row_cl;
	logic [ColW-1:0] col_cl;
	logic [RowW-1:0] row_s1;
	logic [ColW-1:0] col_s1;
	logic [8:0]      shade_s1;

	always_comb begin
		if (in_row[11]) begin
			row_cl = '0;
		end else if (in_row > 12'(ROWS - 1)) begin
			row_cl = RowW'(ROWS - 1);
		end else begin
			row_cl = in_row[RowW-1:0];
		end
		if (in_col[11]) begin
			col_cl = '0;
		end else if (in_col > 12'(COLUMNS - 1)) begin
			col_cl = ColW'(COLUMNS - 1);
		end else begin
			col_cl = in_col[ColW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			row_s1   <= row_cl;
			col_s1   <= col_cl;
			shade_s1 <= sat_unit(in_shade);
		end
	end

	// stage 2: cell number, shade times palette size
	logic [31:0] cell_wide;
	logic [8:0]  size_eff, size_m1;
	logic [17:0] slot_prod;
	logic [12:0] cell_s2;
	logic [8:0]  slot_raw_s2;
	logic [7:0]  size_m1_s2;

	assign cell_wide = 32'(row_s1) * 32'(COLUMNS) + 32'(col_s1);

	// a size of zero acts as one, anything above 256 as 256
	always_comb begin
		if (palette_q == 9'd0) begin
			size_eff = 9'd1;
		end else if (palette_q > UNIT_FP) begin
			size_eff = UNIT_FP;
		end else begin
			size_eff = palette_q;
		end
	end

	assign size_m1   = size_eff - 9'd1;
	assign slot_prod = 18'(shade_s1) * 18'(size_eff);

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			cell_s2     <= cell_wide[12:0];
			slot_raw_s2 <= slot_prod[16:8];
			size_m1_s2  <= size_m1[7:0];
		end
	end

	// stage 3: full shade lands on the last slot
	logic [12:0] cell_s3, cell_s4, cell_s5;
	logic [7:0]  slot_s3, slot_s4, slot_s5;

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			cell_s3 <= cell_s2;
			slot_s3 <= (slot_raw_s2 > {1'b0, size_m1_s2}) ? size_m1_s2 : slot_raw_s2[7:0];
		end
		if (rdy[4]) begin
			cell_s4 <= cell_s3;
			slot_s4 <= slot_s3;
		end
		if (rdy[5]) begin
			cell_s5 <= cell_s4;
			slot_s5 <= slot_s4;
		end
	end

	// stage 6: decimal text and output register
	logic [M_TDATA_W-1:0] m_tdata_s6;

	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			m_tdata_s6 <= {3'b000, slot_s5, byte_text(blue_s5), byte_text(green_s5),
				byte_text(red_s5), blue_s5, green_s5, red_s5, cell_s5};
		end
	end

	assign m_tdata = m_tdata_s6;

	// checks
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (vld_q == 6'b111111))
		else $error("request blocked with an empty stage");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_q[1])
		else $error("accepted request missing from stage one");

	a_text_digit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[60:53] >= 8'h30 && m_tdata[60:53] <= 8'h32))
		else $error("red hundreds digit out of range");

endmodule
`default_nettype wire
